// File: rtl/cbt_pkg.sv
// Shared types and constants for the cubic Bezier tessellator.
`timescale 1ns / 1ps

package cbt_pkg;

  // Fixed-point formats.
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEP   = FRAC_BITS / DIV_STAGES;
  localparam int unsigned WEIGHT_W   = FRAC_BITS + 1;
  localparam int unsigned ACC_W      = 48;

  // One in Q1.16, which is the curve parameter at the final step.
  localparam logic [FRAC_BITS:0] ONE_Q16 = 17'h10000;

  // Register map: the register index is bit 2 of the byte address.
  localparam logic       REG_SEG_COUNT   = 1'b0;
  localparam logic [6:0] SEG_COUNT_RESET = 7'd16;

  typedef logic signed [31:0]   coord_t;
  typedef logic [WEIGHT_W-1:0]  weight_t;
  typedef logic [FRAC_BITS:0]   param_t;

  // Four control points of one curve.
  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p0_z;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    coord_t p3_x;
    coord_t p3_y;
    coord_t p3_z;
  } pts_t;

  // One line segment of the tessellated curve.
  typedef struct packed {
    coord_t from_x;
    coord_t from_y;
    coord_t from_z;
    coord_t to_x;
    coord_t to_y;
    coord_t to_z;
    logic   last_segment;
  } seg_t;

  // Control that travels with each step down the pipeline.
  typedef struct packed {
    logic first;
    logic last;
    logic bank;
  } step_ctl_t;

  // Frees a control point bank once its last step has read it.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

// File: rtl/cbt_seq.sv
// Control point banks and the step sequencer that issues one step per cycle while en is high.
`timescale 1ns / 1ps

module cbt_seq import cbt_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64,
  localparam int unsigned NW = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [6:0]    seg_count,
  input  logic          pts_valid,
  input  pts_t          pts_in,
  output logic          pts_stall,
  input  release_t      rel,
  input  logic          rd_bank,
  output pts_t          rd_pts,
  output logic          iss_valid,
  output logic [NW-1:0] iss_i,
  output logic [NW-1:0] iss_n,
  output step_ctl_t     iss_ctl
);

  pts_t          bank [2];
  logic [NW-1:0] bank_n [2];
  logic [1:0]    pend;
  logic [1:0]    busy;
  logic          load_sel;
  logic          issue_sel;
  logic [NW-1:0] cnt;
  logic [NW-1:0] n_eff;
  logic          accept;
  logic          load;
  logic          issue_last;

  // Segment count saturates at the largest supported value.
  assign n_eff = (seg_count > 7'(MAX_SEGMENTS)) ? NW'(MAX_SEGMENTS) : seg_count[NW-1:0];

  // An item is taken whenever the bank it would land in is free.
  assign pts_stall  = busy[load_sel];
  assign accept     = pts_valid && !busy[load_sel];
  assign load       = accept && (n_eff != '0);
  assign issue_last = (cnt == bank_n[issue_sel]);
  assign rd_pts     = bank[rd_bank];

  // Bank contents; a curve with no segments is dropped.
  always_ff @(posedge clk) begin
    if (load) begin
      bank[load_sel]   <= pts_in;
      bank_n[load_sel] <= n_eff;
    end
  end

  // Bank occupancy and the step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      busy      <= '0;
      load_sel  <= 1'b0;
      issue_sel <= 1'b0;
      cnt       <= NW'(1);
      iss_valid <= 1'b0;
    end else begin
      if (rel.valid) begin
        busy[rel.bank] <= 1'b0;
      end
      if (load) begin
        busy[load_sel] <= 1'b1;
        pend[load_sel] <= 1'b1;
        load_sel       <= !load_sel;
      end
      if (en) begin
        iss_valid <= pend[issue_sel];
        if (pend[issue_sel]) begin
          if (issue_last) begin
            pend[issue_sel] <= 1'b0;
            issue_sel       <= !issue_sel;
            cnt             <= NW'(1);
          end else begin
            cnt <= NW'(cnt + 1'b1);
          end
        end
      end
    end
  end

  // Step payload for the parameter divider.
  always_ff @(posedge clk) begin
    if (en && pend[issue_sel]) begin
      iss_i         <= cnt;
      iss_n         <= bank_n[issue_sel];
      iss_ctl.first <= (cnt == NW'(1));
      iss_ctl.last  <= issue_last;
      iss_ctl.bank  <= issue_sel;
    end
  end

endmodule

// File: rtl/cbt_tdiv.sv
// Pipelined long divider that forms the curve parameter t = i / n in Q1.16.
`timescale 1ns / 1ps

module cbt_tdiv import cbt_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64,
  localparam int unsigned NW = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] i,
  input  logic [NW-1:0] n,
  input  step_ctl_t     in_ctl,
  output logic          out_valid,
  output param_t        t,
  output step_ctl_t     out_ctl
);

  logic                 sv    [DIV_STAGES+1];
  logic                 sfull [DIV_STAGES+1];
  logic [NW-1:0]        srem  [DIV_STAGES+1];
  logic [NW-1:0]        sn    [DIV_STAGES+1];
  logic [FRAC_BITS-1:0] sq    [DIV_STAGES+1];
  step_ctl_t            sctl  [DIV_STAGES+1];

  // The final step has t equal to one; every other step has i below n.
  assign sv[0]    = in_valid;
  assign sfull[0] = (i == n);
  assign srem[0]  = (i == n) ? '0 : i;
  assign sn[0]    = n;
  assign sq[0]    = '0;
  assign sctl[0]  = in_ctl;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NW-1:0]        rem_c;
    logic [FRAC_BITS-1:0] q_c;

    // DIV_STEP restoring division steps per stage on the narrow remainder.
    always_comb begin
      logic [NW:0] trial;
      rem_c = srem[s];
      q_c   = sq[s];
      for (int k = 0; k < DIV_STEP; k++) begin
        trial = {rem_c, 1'b0};
        if (trial >= {1'b0, sn[s]}) begin
          trial = trial - {1'b0, sn[s]};
          q_c   = {q_c[FRAC_BITS-2:0], 1'b1};
        end else begin
          q_c   = {q_c[FRAC_BITS-2:0], 1'b0};
        end
        rem_c = trial[NW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s+1] <= 1'b0;
      end else if (en) begin
        sv[s+1] <= sv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sfull[s+1] <= sfull[s];
        srem[s+1]  <= rem_c;
        sn[s+1]    <= sn[s];
        sq[s+1]    <= q_c;
        sctl[s+1]  <= sctl[s];
      end
    end
  end

  assign out_valid = sv[DIV_STAGES];
  assign t         = sfull[DIV_STAGES] ? ONE_Q16 : {1'b0, sq[DIV_STAGES]};
  assign out_ctl   = sctl[DIV_STAGES];

endmodule

// File: rtl/cbt_weight.sv
// Three-stage pipeline for the Bernstein weights u^3, 3u^2t, 3ut^2 and t^3.
`timescale 1ns / 1ps

module cbt_weight import cbt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  param_t            t,
  input  step_ctl_t         in_ctl,
  output logic              out_valid,
  output weight_t [3:0]     w,
  output step_ctl_t         out_ctl
);

  // t is never zero, so u always fits in sixteen bits.
  logic [FRAC_BITS-1:0] u_c;
  logic [FRAC_BITS:0]   u_wide;

  logic                 v1;
  logic [15:0]          u1;
  logic [16:0]          t1;
  logic [31:0]          uu1;
  logic [33:0]          tt1;
  step_ctl_t            ctl1;

  logic                 v2;
  logic [47:0]          u3_2;
  logic [48:0]          u2t_2;
  logic [49:0]          ut2_2;
  logic [50:0]          t3_2;
  step_ctl_t            ctl2;

  logic [50:0]          u2t_x3;
  logic [50:0]          ut2_x3;

  assign u_wide = ONE_Q16 - t;
  assign u_c    = u_wide[FRAC_BITS-1:0];

  // Tripled products, worked out with a shift and an add.
  assign u2t_x3 = {2'b00, u2t_2} + {1'b0, u2t_2, 1'b0};
  assign ut2_x3 = {1'b0, ut2_2} + {ut2_2, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Squares.
      u1    <= u_c;
      t1    <= t;
      uu1   <= {16'b0, u_c} * {16'b0, u_c};
      tt1   <= {17'b0, t} * {17'b0, t};
      ctl1  <= in_ctl;
      // Cubes and mixed terms.
      u3_2  <= {16'b0, uu1} * {32'b0, u1};
      u2t_2 <= {17'b0, uu1} * {32'b0, t1};
      ut2_2 <= {16'b0, tt1} * {34'b0, u1};
      t3_2  <= {17'b0, tt1} * {34'b0, t1};
      ctl2  <= ctl1;
      // Truncate to Q1.16.
      w[0]    <= {1'b0, u3_2[47:32]};
      w[1]    <= u2t_x3[48:32];
      w[2]    <= ut2_x3[48:32];
      w[3]    <= t3_2[48:32];
      out_ctl <= ctl2;
    end
  end

endmodule

// File: rtl/cbt_eval.sv
// Weighted sum of the control points per axis and the segment output register.
`timescale 1ns / 1ps

module cbt_eval import cbt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  weight_t [3:0] w,
  input  step_ctl_t     in_ctl,
  input  pts_t          pts,
  output logic          seg_valid,
  output seg_t          seg
);

  coord_t            c    [3][4];
  logic signed [49:0] m    [3][4];

  logic              v1;
  logic [ACC_W-1:0]  prod [3][4];
  coord_t            p0_1 [3];
  step_ctl_t         ctl1;

  logic              v2;
  logic [ACC_W-1:0]  s01  [3];
  logic [ACC_W-1:0]  s23  [3];
  coord_t            p0_2 [3];
  step_ctl_t         ctl2;

  logic [ACC_W-1:0]  sum  [3];
  coord_t            pt   [3];
  coord_t            prev [3];

  // Coefficients by axis and control point.
  assign c[0][0] = pts.p0_x;
  assign c[0][1] = pts.p1_x;
  assign c[0][2] = pts.p2_x;
  assign c[0][3] = pts.p3_x;
  assign c[1][0] = pts.p0_y;
  assign c[1][1] = pts.p1_y;
  assign c[1][2] = pts.p2_y;
  assign c[1][3] = pts.p3_y;
  assign c[2][0] = pts.p0_z;
  assign c[2][1] = pts.p1_z;
  assign c[2][2] = pts.p2_z;
  assign c[2][3] = pts.p3_z;

  // Unsigned weight times signed coordinate.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 4; k++) begin
        m[a][k] = $signed({1'b0, w[k]}) * c[a][k];
      end
    end
  end

  // Only bits 47..16 of the sum reach the output, so all sums wrap at 48 bits.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = s01[a] + s23[a];
      pt[a]  = sum[a][47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      seg_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      seg_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Products.
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 4; k++) begin
          prod[a][k] <= m[a][k][ACC_W-1:0];
        end
        p0_1[a] <= c[a][0];
      end
      ctl1 <= in_ctl;
      // Pairwise sums.
      for (int a = 0; a < 3; a++) begin
        s01[a]  <= prod[a][0] + prod[a][1];
        s23[a]  <= prod[a][2] + prod[a][3];
        p0_2[a] <= p0_1[a];
      end
      ctl2 <= ctl1;
    end
  end

  // Segment register: each segment starts where the previous one ended, the first of a curve at P0.
  always_ff @(posedge clk) begin
    if (en && v2) begin
      seg.from_x       <= ctl2.first ? p0_2[0] : prev[0];
      seg.from_y       <= ctl2.first ? p0_2[1] : prev[1];
      seg.from_z       <= ctl2.first ? p0_2[2] : prev[2];
      seg.to_x         <= pt[0];
      seg.to_y         <= pt[1];
      seg.to_z         <= pt[2];
      seg.last_segment <= ctl2.last;
      for (int a = 0; a < 3; a++) begin
        prev[a] <= pt[a];
      end
    end
  end

endmodule

// File: rtl/cubic_bezier_tessellator_top.sv
// Top level of the cubic Bezier tessellator: register port, sequencer and pipeline.
`timescale 1ns / 1ps

// Each item is four 3D control points in signed Q16.16; the block answers with
// segment_count line segments (saturated at MAX_SEGMENTS) along the cubic Bezier
// curve, the last one flagged, and nothing at all for a count of zero. One
// evaluation pipeline produces one segment per cycle unless the output stalls,
// and segment_count is 16 at reset. Each step passes the sequencer, the
// divider, the weight stages and the evaluation stages in turn. Two control
// point banks let the next item be taken while the previous curve is still
// being evaluated, and the pipeline only halts while a finished segment waits
// at the output. For fewer than nine segments the banks set the pace instead:
// a bank is held from the item being taken until the last step of its curve
// leaves the weight stages.
// segment_count is read at byte address 0 and may only be changed while idle.

module cubic_bezier_tessellator_top import cbt_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        pts_valid,
  output logic        pts_stall,
  input  pts_t        pts,
  output logic        seg_valid,
  input  logic        seg_stall,
  output seg_t        seg
);

  localparam int unsigned NW = $clog2(MAX_SEGMENTS + 1);

  logic [6:0]    seg_count;
  logic          en;
  release_t      rel;
  pts_t          rd_pts;

  logic          iss_valid;
  logic [NW-1:0] iss_i;
  logic [NW-1:0] iss_n;
  step_ctl_t     iss_ctl;

  logic          t_valid;
  param_t        t;
  step_ctl_t     t_ctl;

  logic          w_valid;
  weight_t [3:0] w;
  step_ctl_t     w_ctl;

  // Register port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEG_COUNT) ? {25'b0, seg_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= SEG_COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SEG_COUNT)) begin
      seg_count <= pwdata[6:0];
    end
  end

  // The whole pipeline moves unless a segment is held at the output.
  assign en = !seg_valid || !seg_stall;

  // A bank is free once its last step has taken its products.
  assign rel.valid = en && w_valid && w_ctl.last;
  assign rel.bank  = w_ctl.bank;

  cbt_seq #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .seg_count (seg_count),
    .pts_valid (pts_valid),
    .pts_in    (pts),
    .pts_stall (pts_stall),
    .rel       (rel),
    .rd_bank   (w_ctl.bank),
    .rd_pts    (rd_pts),
    .iss_valid (iss_valid),
    .iss_i     (iss_i),
    .iss_n     (iss_n),
    .iss_ctl   (iss_ctl)
  );

  cbt_tdiv #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (iss_valid),
    .i         (iss_i),
    .n         (iss_n),
    .in_ctl    (iss_ctl),
    .out_valid (t_valid),
    .t         (t),
    .out_ctl   (t_ctl)
  );

  cbt_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t_valid),
    .t         (t),
    .in_ctl    (t_ctl),
    .out_valid (w_valid),
    .w         (w),
    .out_ctl   (w_ctl)
  );

  cbt_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (w_valid),
    .w         (w),
    .in_ctl    (w_ctl),
    .pts       (rd_pts),
    .seg_valid (seg_valid),
    .seg       (seg)
  );

  // Checks: segments of one curve join up, and the block is open after reset.
  logic   chk_mid;
  coord_t chk_x;
  coord_t chk_y;
  coord_t chk_z;
  logic   seg_acc;

  assign seg_acc = seg_valid && !seg_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_mid <= 1'b0;
    end else if (seg_acc) begin
      chk_mid <= !seg.last_segment;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_acc) begin
      chk_x <= seg.to_x;
      chk_y <= seg.to_y;
      chk_z <= seg.to_z;
    end
  end

  a_seg_joined: assert property (@(posedge clk) disable iff (rst)
    seg_acc && chk_mid |->
      (seg.from_x == chk_x) && (seg.from_y == chk_y) && (seg.from_z == chk_z))
    else $error("segment does not start where the previous one ended");

  a_open_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !pts_stall)
    else $error("input stalled straight after reset");

endmodule
